// ===== src/lorf_pkg.sv =====
// Shared types, constants and helpers for the longest open reading frame scan.
package lorf_pkg;

  // Width of the length and position fields.
  localparam int unsigned LEN_W = 17;
  // Longest run or position that is counted; counts saturate here.
  localparam logic [LEN_W-1:0] MAX_BASES = LEN_W'(65536);
  // Bases per codon.
  localparam logic [LEN_W-1:0] CODON_BASES = LEN_W'(3);

  // ASCII base characters used for codon matching.
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_SHIFT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH  = 1'b1;

  // Queue between the classifier and the scan datapath.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Codon class as decided by the front end.
  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } codon_kind_t;

  // One queued codon.
  typedef struct packed {
    codon_kind_t kind;
    logic        last;
  } codon_item_t;

  // Add one codon of bases and saturate at MAX_BASES.
  function automatic logic [LEN_W-1:0] sat_add3(input logic [LEN_W-1:0] v);
    logic [LEN_W:0] sum;
    sum = {1'b0, v} + {1'b0, CODON_BASES};
    sat_add3 = (sum > {1'b0, MAX_BASES}) ? MAX_BASES : sum[LEN_W-1:0];
  endfunction

endpackage

// ===== src/longest_open_reading_frame_scan.sv =====
// Top level of the longest open reading frame scan: configuration and wiring.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   base_first, base_second, base_third, last_codon
//   out_     output     out_valid/out_stall longest_length, orf_start, orf_end, meets_minimum
//   cfg_     input      cfg_valid/cfg_ready cfg_index (0 frame_shift, 1 min_length), cfg_data
//
// One codon is taken every cycle while the queue has room; the scan update is one compare and
// one add per codon. A result passes from the four-entry codon queue through the
// end-of-sequence snapshot into the result register before it is offered. Reset clears the
// queue, the scan state and both registers.
// A stalled result holds its slot; further codons keep filling the queue, and in_stall
// rises only when the queue is full. Configuration writes are always taken.
module longest_open_reading_frame_scan
  import lorf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_base_first,
  input  logic [7:0]           in_base_second,
  input  logic [7:0]           in_base_third,
  input  logic                 in_last_codon,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LEN_W-1:0]     out_longest_length,
  output logic [LEN_W-1:0]     out_orf_start,
  output logic [LEN_W-1:0]     out_orf_end,
  output logic                 out_meets_minimum,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);

  logic [1:0]       frame_shift_r;
  logic [LEN_W-1:0] min_length_r;

  logic             push;
  codon_item_t      push_item;
  logic             queue_full;
  logic             pop;
  logic             head_valid;
  codon_item_t      head_item;

  // Configuration registers accept a write every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_shift_r <= '0;
      min_length_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_SHIFT: frame_shift_r <= cfg_data[1:0];
        REG_MIN_LENGTH:  min_length_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lorf_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_base_first  (in_base_first),
    .in_base_second (in_base_second),
    .in_base_third  (in_base_third),
    .in_last_codon  (in_last_codon),
    .queue_full     (queue_full),
    .push           (push),
    .push_item      (push_item)
  );

  lorf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  lorf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_valid         (head_valid),
    .head_item          (head_item),
    .pop                (pop),
    .frame_shift        (frame_shift_r),
    .min_length         (min_length_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_longest_length (out_longest_length),
    .out_orf_start      (out_orf_start),
    .out_orf_end        (out_orf_end),
    .out_meets_minimum  (out_meets_minimum)
  );

endmodule

// ===== src/lorf_front.sv =====
// Front end: takes codon transfers and classifies them as start, stop or other.
module lorf_front
  import lorf_pkg::*;
(
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_base_first,
  input  logic [7:0]  in_base_second,
  input  logic [7:0]  in_base_third,
  input  logic        in_last_codon,
  input  logic        queue_full,
  output logic        push,
  output codon_item_t push_item
);

  logic is_start;
  logic is_stop;

  // Exact uppercase match on ATG and on TAA, TGA, TAG.
  assign is_start = (in_base_first == CHAR_A) && (in_base_second == CHAR_T) &&
                    (in_base_third == CHAR_G);
  assign is_stop  = (in_base_first == CHAR_T) &&
                    (((in_base_second == CHAR_A) && (in_base_third == CHAR_A)) ||
                     ((in_base_second == CHAR_G) && (in_base_third == CHAR_A)) ||
                     ((in_base_second == CHAR_A) && (in_base_third == CHAR_G)));

  always_comb begin
    if (is_start) begin
      push_item.kind = KIND_START;
    end else if (is_stop) begin
      push_item.kind = KIND_STOP;
    end else begin
      push_item.kind = KIND_OTHER;
    end
    push_item.last = in_last_codon;
  end

  // A transfer goes straight into the queue whenever it has room.
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

endmodule

// ===== src/lorf_queue.sv =====
// Short queue of classified codons between the front end and the scan datapath.
module lorf_queue
  import lorf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  codon_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output codon_item_t head_item
);

  codon_item_t               slots_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]         count_r, count_nxt;

  assign full       = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = slots_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/lorf_back.sv =====
// Scan datapath: tracks the open run and the best run, and forms the result.
module lorf_back
  import lorf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  codon_item_t      head_item,
  output logic             pop,
  input  logic [1:0]       frame_shift,
  input  logic [LEN_W-1:0] min_length,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LEN_W-1:0] out_longest_length,
  output logic [LEN_W-1:0] out_orf_start,
  output logic [LEN_W-1:0] out_orf_end,
  output logic             out_meets_minimum
);

  // Scan state.
  logic             run_open_r, run_open_nxt;
  logic [LEN_W-1:0] run_len_r, run_len_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] best_len_r, best_len_nxt;
  logic [LEN_W-1:0] best_start_r, best_start_nxt;
  logic [LEN_W-1:0] best_end_r, best_end_nxt;

  // Sequence-end snapshot, before the trailing run is compared.
  logic             fin_valid_r;
  logic [LEN_W-1:0] fin_run_len_r;
  logic [LEN_W-1:0] fin_pos_r;
  logic [LEN_W-1:0] fin_best_len_r;
  logic [LEN_W-1:0] fin_best_start_r;
  logic [LEN_W-1:0] fin_best_end_r;
  logic             fin_move;

  // Result register.
  logic             out_valid_r;
  logic [LEN_W-1:0] out_len_r, out_len_nxt;
  logic [LEN_W-1:0] out_start_r, out_start_nxt;
  logic [LEN_W-1:0] out_end_r, out_end_nxt;
  logic             out_meets_r, out_meets_nxt;

  logic             take_run;
  logic             take_tail;
  logic [LEN_W-1:0] tail_start;
  logic [LEN_W-1:0] shift_ext;

  // Result register frees when empty or when its transfer completes.
  assign fin_move = fin_valid_r && (!out_valid_r || !out_stall);
  // A sequence end waits until the snapshot slot is free.
  assign pop = head_valid && (!head_item.last || !fin_valid_r || fin_move);

  // Per-codon update of the open run and the best run.
  always_comb begin
    run_open_nxt   = run_open_r;
    run_len_nxt    = run_len_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    best_end_nxt   = best_end_r;
    take_run       = (run_len_r > best_len_r);
    unique case (head_item.kind)
      KIND_START: begin
        run_open_nxt = 1'b1;
      end
      KIND_STOP: begin
        run_open_nxt = 1'b0;
        run_len_nxt  = '0;
        if (take_run) begin
          best_len_nxt   = run_len_r;
          best_end_nxt   = pos_r;
          best_start_nxt = pos_r - run_len_r;
        end
      end
      default: begin
      end
    endcase
    if (run_open_nxt) begin
      run_len_nxt = sat_add3(run_len_nxt);
    end
    pos_nxt = sat_add3(pos_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r   <= 1'b1;
      run_len_r    <= '0;
      pos_r        <= '0;
      best_len_r   <= '0;
      best_start_r <= '0;
      best_end_r   <= '0;
    end else if (pop) begin
      if (head_item.last) begin
        // Sequence end: the scan starts over for the next sequence.
        run_open_r   <= 1'b1;
        run_len_r    <= '0;
        pos_r        <= '0;
        best_len_r   <= '0;
        best_start_r <= '0;
        best_end_r   <= '0;
      end else begin
        run_open_r   <= run_open_nxt;
        run_len_r    <= run_len_nxt;
        pos_r        <= pos_nxt;
        best_len_r   <= best_len_nxt;
        best_start_r <= best_start_nxt;
        best_end_r   <= best_end_nxt;
      end
    end
  end

  // Snapshot valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (pop && head_item.last) begin
      fin_valid_r <= 1'b1;
    end else if (fin_move) begin
      fin_valid_r <= 1'b0;
    end
  end

  // Snapshot payload.
  always_ff @(posedge clk) begin
    if (pop && head_item.last) begin
      fin_run_len_r    <= run_len_nxt;
      fin_pos_r        <= pos_nxt;
      fin_best_len_r   <= best_len_nxt;
      fin_best_start_r <= best_start_nxt;
      fin_best_end_r   <= best_end_nxt;
    end
  end

  // Trailing run compare, frame shift and minimum check.
  always_comb begin
    take_tail  = (fin_run_len_r > fin_best_len_r);
    tail_start = fin_pos_r - fin_run_len_r;
    shift_ext  = {{(LEN_W-2){1'b0}}, frame_shift};
    if (take_tail) begin
      out_len_nxt   = fin_run_len_r;
      out_start_nxt = tail_start + shift_ext;
      out_end_nxt   = fin_pos_r + shift_ext;
      out_meets_nxt = (fin_run_len_r >= min_length);
    end else begin
      out_len_nxt   = fin_best_len_r;
      out_start_nxt = fin_best_start_r + shift_ext;
      out_end_nxt   = fin_best_end_r + shift_ext;
      out_meets_nxt = (fin_best_len_r >= min_length);
    end
    // With no run found both positions report zero.
    if (out_len_nxt == '0) begin
      out_start_nxt = '0;
      out_end_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      out_len_r   <= out_len_nxt;
      out_start_r <= out_start_nxt;
      out_end_r   <= out_end_nxt;
      out_meets_r <= out_meets_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_longest_length = out_len_r;
  assign out_orf_start      = out_start_r;
  assign out_orf_end        = out_end_r;
  assign out_meets_minimum  = out_meets_r;

endmodule
